@@ src/proximity_zone_hysteresis_dwell_macros.svh @@
`ifndef PROXIMITY_ZONE_HYSTERESIS_DWELL_MACROS_SVH
`define PROXIMITY_ZONE_HYSTERESIS_DWELL_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside of reset.
`define PZHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside of reset.
`define PZHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked while reset is high.
`define PZHD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pzhd_pkg.sv @@
`timescale 1ns / 1ps

package pzhd_pkg;

   typedef enum logic [1:0] {
      ZONE_SAFE    = 2'd0,
      ZONE_CAUTION = 2'd1,
      ZONE_DANGER  = 2'd2
   } zone_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int DWELL_BITS     = 31;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_CAUTION_ENTER = 3'd0;
   localparam csr_index_type CSR_CAUTION_EXIT  = 3'd1;
   localparam csr_index_type CSR_DANGER_ENTER  = 3'd2;
   localparam csr_index_type CSR_DANGER_EXIT   = 3'd3;
   localparam csr_index_type CSR_MIN_DWELL     = 3'd4;

   // Next values of the zone state for one word.
   typedef struct packed {
      logic     restart;
      zone_type pending;
      zone_type current;
   } zone_update_type;

endpackage

@@ src/pzhd_zone_step.sv @@
`timescale 1ns / 1ps

module pzhd_zone_step
   import pzhd_pkg::*;
#(
   parameter int DISTANCE_BITS = 16,
   parameter int TIME_BITS     = 32
) (
   input  logic [DISTANCE_BITS-1:0] caution_enter_lim,
   input  logic [DISTANCE_BITS-1:0] caution_exit_lim,
   input  logic [DISTANCE_BITS-1:0] danger_enter_lim,
   input  logic [DISTANCE_BITS-1:0] danger_exit_lim,
   input  logic [DWELL_BITS-1:0]    dwell_lim,
   input  logic [DISTANCE_BITS-1:0] sample_range,
   input  logic [TIME_BITS-1:0]     now_ms,
   input  zone_type                 current_zone,
   input  zone_type                 pending_zone,
   input  logic [TIME_BITS-1:0]     pending_start,
   output zone_update_type          update
);

   localparam int CMP_BITS = (TIME_BITS > DWELL_BITS) ? TIME_BITS : DWELL_BITS;

   zone_type             candidate;
   logic                 restart;
   logic [TIME_BITS-1:0] elapsed;
   logic [CMP_BITS-1:0]  elapsed_wide;
   logic [CMP_BITS-1:0]  dwell_wide;
   logic                 dwell_met;

   always_comb begin
      if ((sample_range <= danger_enter_lim) ||
          ((current_zone == ZONE_DANGER) && (sample_range <= danger_exit_lim))) begin
         candidate = ZONE_DANGER;
      end else if ((sample_range <= caution_enter_lim) ||
                   ((current_zone != ZONE_SAFE) && (sample_range <= caution_exit_lim))) begin
         candidate = ZONE_CAUTION;
      end else begin
         candidate = ZONE_SAFE;
      end
   end

   // A changed candidate restarts the timer at this sample, so it has seen no time yet.
   assign restart      = (candidate != pending_zone);
   assign elapsed      = restart ? '0 : (now_ms - pending_start);
   assign elapsed_wide = CMP_BITS'(elapsed);
   assign dwell_wide   = CMP_BITS'(dwell_lim);
   assign dwell_met    = (elapsed_wide >= dwell_wide);

   always_comb begin
      update.restart = restart;
      update.pending = candidate;
      update.current = ((candidate != current_zone) && dwell_met) ? candidate : current_zone;
   end

endmodule

@@ src/proximity_zone_hysteresis_dwell.sv @@
`timescale 1ns / 1ps

// Classifies distance samples into safe, caution or danger with separate enter and
// exit thresholds, and reports a new zone only after it has held for the programmed
// dwell time. One word is accepted every clock cycle unless the input stalls.
// A word is held in the input register, where the threshold compares and the one
// timestamp subtraction run, and its zone is loaded into the result register as the
// word advances. A stalled result holds the input register, and the input stalls
// only during reset or while both registers are full and the result is stalled.
// The zone state is updated as a word moves from the input register into the
// result register, so the following word already sees it. Registers on the csr_
// port must be written while no word is in flight; indexes past the dwell register
// are ignored.
module proximity_zone_hysteresis_dwell
   import pzhd_pkg::*;
#(
   parameter int DISTANCE_BITS = 16,
   parameter int TIME_BITS     = 32,
   localparam int CSR_DATA_BITS = (DISTANCE_BITS > DWELL_BITS) ? DISTANCE_BITS : DWELL_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [DISTANCE_BITS-1:0] req_range_mm,
   input  logic [TIME_BITS-1:0]     req_now_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_zone
);

   logic [DISTANCE_BITS-1:0] caution_enter_ff;
   logic [DISTANCE_BITS-1:0] caution_exit_ff;
   logic [DISTANCE_BITS-1:0] danger_enter_ff;
   logic [DISTANCE_BITS-1:0] danger_exit_ff;
   logic [DWELL_BITS-1:0]    min_dwell_ff;

   zone_type                 current_zone_ff;
   zone_type                 pending_zone_ff;
   logic [TIME_BITS-1:0]     pending_start_ff;

   logic                     in_valid_ff;
   logic [DISTANCE_BITS-1:0] in_distance_ff;
   logic [TIME_BITS-1:0]     in_now_ff;
   logic                     out_valid_ff;
   zone_type                 out_zone_ff;

   logic                     req_take;
   logic                     advance;
   zone_update_type          update;

   // The input word moves on whenever the result register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = reset || (in_valid_ff && !advance);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         caution_enter_ff <= '0;
         caution_exit_ff  <= '0;
         danger_enter_ff  <= '0;
         danger_exit_ff   <= '0;
         min_dwell_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CAUTION_ENTER: caution_enter_ff <= csr_wdata[DISTANCE_BITS-1:0];
            CSR_CAUTION_EXIT:  caution_exit_ff  <= csr_wdata[DISTANCE_BITS-1:0];
            CSR_DANGER_ENTER:  danger_enter_ff  <= csr_wdata[DISTANCE_BITS-1:0];
            CSR_DANGER_EXIT:   danger_exit_ff   <= csr_wdata[DISTANCE_BITS-1:0];
            CSR_MIN_DWELL:     min_dwell_ff     <= csr_wdata[DWELL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   pzhd_zone_step #(
      .DISTANCE_BITS (DISTANCE_BITS),
      .TIME_BITS     (TIME_BITS)
   ) u_zone_step (
      .caution_enter_lim (caution_enter_ff),
      .caution_exit_lim  (caution_exit_ff),
      .danger_enter_lim  (danger_enter_ff),
      .danger_exit_lim   (danger_exit_ff),
      .dwell_lim         (min_dwell_ff),
      .sample_range      (in_distance_ff),
      .now_ms            (in_now_ff),
      .current_zone      (current_zone_ff),
      .pending_zone      (pending_zone_ff),
      .pending_start     (pending_start_ff),
      .update            (update)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         current_zone_ff  <= ZONE_SAFE;
         pending_zone_ff  <= ZONE_SAFE;
         pending_start_ff <= '0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (advance) begin
            current_zone_ff <= update.current;
            pending_zone_ff <= update.pending;
            if (update.restart) begin
               pending_start_ff <= in_now_ff;
            end
         end
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_distance_ff <= req_range_mm;
         in_now_ff      <= req_now_ms;
      end
      if (advance) begin
         out_zone_ff <= update.current;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_zone  = out_zone_ff;

endmodule

@@ src/pzhd_checker.sv @@
`timescale 1ns / 1ps
`include "proximity_zone_hysteresis_dwell_macros.svh"

module pzhd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_zone
);

   `PZHD_ASSERT_NOW(a_zone_code, clock, reset, rsp_valid, rsp_zone != 2'd3, "rsp_zone holds an unused code")
   `PZHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_zone), "stalled result word changed")
   `PZHD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")
   `PZHD_ASSERT_NOW(a_rsp_latency, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result word without an input word two cycles earlier")

endmodule

bind proximity_zone_hysteresis_dwell pzhd_checker u_pzhd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_zone  (rsp_zone)
);
